[hw/rtl/prtr_pkg.sv]
// Shared types and constants for the pausable run timer relay.
// Used by prtr_div and pausable_run_timer_relay; no dependencies.
package prtr_pkg;

    // Field widths
    localparam int unsigned TIME_W     = 20;
    localparam int unsigned ELAPSED_W  = 10;
    localparam int unsigned PCT_W      = 7;
    localparam int unsigned MODE_W     = 2;
    localparam int unsigned CFG_IDX_W  = 1;

    // Percent scaling: remaining * 100 needs TIME_W + PCT_W bits
    localparam int unsigned DIVIDEND_W = TIME_W + PCT_W;
    localparam int unsigned DIV_CNT_W  = $clog2(DIVIDEND_W);
    localparam logic [PCT_W-1:0] PCT_FULL = PCT_W'(100);

    // Register reset values and defaults
    localparam logic [TIME_W-1:0] DURATION_RST      = TIME_W'(10000);
    localparam logic [TIME_W-1:0] PAUSE_TIMEOUT_RST = TIME_W'(3000);
    localparam int unsigned       FINISH_HOLD_MS_DEF = 1000;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DURATION      = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_PAUSE_TIMEOUT = CFG_IDX_W'(1);

    // Operating mode, encoded as seen on the mode output
    typedef enum logic [MODE_W-1:0] {
        MODE_OFF = 2'd0,
        MODE_RUN = 2'd1,
        MODE_INT = 2'd2,
        MODE_FIN = 2'd3
    } mode_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_DIV,
        ST_PUSH
    } seq_state_t;

    // Divider request and response
    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [TIME_W-1:0]     divisor;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic [DIVIDEND_W-1:0] quotient;
    } div_rsp_t;

endpackage

[hw/rtl/prtr_div.sv]
// Serial restoring divider, one quotient bit per cycle.
// Depends on prtr_pkg for widths and the request/response structs.
module prtr_div (
    input  logic                aclk,
    input  logic                aresetn,
    input  prtr_pkg::div_req_t  div_req,
    output prtr_pkg::div_rsp_t  div_rsp
);
    import prtr_pkg::*;

    logic                  busy_reg;
    logic                  done_reg;
    logic [DIV_CNT_W-1:0]  count_reg;
    logic [TIME_W-1:0]     rem_reg;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [TIME_W-1:0]     divisor_reg;

    logic [TIME_W:0]       trial;
    logic [TIME_W:0]       diff;
    logic                  fits;
    logic [TIME_W-1:0]     rem_next;
    logic [DIVIDEND_W-1:0] quo_next;

    // One trial subtraction step; dividend bits shift out as quotient bits shift in
    always_comb begin
        trial    = {rem_reg, quo_reg[DIVIDEND_W-1]};
        diff     = trial - {1'b0, divisor_reg};
        fits     = (trial >= {1'b0, divisor_reg});
        rem_next = fits ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
        quo_next = {quo_reg[DIVIDEND_W-2:0], fits};
    end

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (div_req.start) begin
                busy_reg  <= 1'b1;
                count_reg <= DIV_CNT_W'(DIVIDEND_W - 1);
            end else if (busy_reg) begin
                count_reg <= count_reg - 1'b1;
                if (count_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        if (div_req.start) begin
            rem_reg     <= '0;
            quo_reg     <= div_req.dividend;
            divisor_reg <= div_req.divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign div_rsp.done     = done_reg;
    assign div_rsp.quotient = quo_reg;

    // A new division is only issued to an idle unit
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_req.start |-> !busy_reg)
        else $error("divider started while busy");

    // Done follows the last iteration
    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> ($past(busy_reg) && !busy_reg))
        else $error("divider done without a running division");

endmodule

[hw/rtl/pausable_run_timer_relay.sv]
// Top level of the pausable run timer relay: step sequencer, mode state and output register.
// Depends on prtr_pkg and the serial divider prtr_div.
//
// Each request is one time step (elapsed ms, button level) and yields exactly one result.
// A step whose new mode is running with a nonzero duration computes the percentage on a
// serial divider that produces one of 27 quotient bits per cycle. Such a step passes through
// the start, divide and push states before its result sits in the output register. Any
// other step goes from acceptance straight to the push state. The next request is accepted
// once the previous result has been loaded into the output register, which holds it while
// the consumer stalls.
// Configuration writes take effect at once and are meant to happen while no step is
// being processed.
module pausable_run_timer_relay #(
    parameter int unsigned FINISH_HOLD_MS = prtr_pkg::FINISH_HOLD_MS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Configuration
    input  logic                             cfg_wr_en,
    input  logic [prtr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [prtr_pkg::TIME_W-1:0]      cfg_wr_data,
    // Step requests
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [prtr_pkg::ELAPSED_W-1:0]   s_elapsed_ms,
    input  logic                             s_pressed,
    // Results
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_relay_on,
    output logic [prtr_pkg::MODE_W-1:0]      m_mode,
    output logic [prtr_pkg::PCT_W-1:0]       m_progress_pct,
    output logic [prtr_pkg::TIME_W-1:0]      m_time_left_ms
);
    import prtr_pkg::*;

    localparam logic [TIME_W-1:0] HOLD_LOAD = TIME_W'(FINISH_HOLD_MS);

    // Configuration registers
    logic [TIME_W-1:0] duration_reg;
    logic [TIME_W-1:0] pause_timeout_reg;

    // Mode state
    mode_t             mode_reg,  mode_next;
    logic [TIME_W-1:0] remaining_reg, remaining_next;
    logic [TIME_W-1:0] saved_reg, saved_next;
    logic [TIME_W-1:0] wait_reg, wait_next;
    logic [PCT_W-1:0]  shown_progress_reg;
    logic [TIME_W-1:0] shown_time_left_reg;

    // Sequencer
    seq_state_t state_reg, state_next;
    logic       accept;
    logic       need_div;
    logic       out_free;
    logic       push;

    // Output register
    logic              m_valid_reg;
    logic              m_relay_on_reg;
    logic [MODE_W-1:0] m_mode_reg;
    logic [PCT_W-1:0]  m_progress_reg;
    logic [TIME_W-1:0] m_time_left_reg;

    // Divider
    div_req_t              div_req;
    div_rsp_t              div_rsp;
    logic [PCT_W-1:0]      pct_capped;
    logic [TIME_W-1:0]     rem_dec;
    logic [TIME_W-1:0]     wait_dec;
    logic [ELAPSED_W-1:0]  elapsed;

    prtr_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .div_req (div_req),
        .div_rsp (div_rsp)
    );

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            duration_reg      <= DURATION_RST;
            pause_timeout_reg <= PAUSE_TIMEOUT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_DURATION:      duration_reg      <= cfg_wr_data;
                REG_PAUSE_TIMEOUT: pause_timeout_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Saturating countdowns for this step
    always_comb begin
        elapsed  = s_elapsed_ms;
        rem_dec  = (remaining_reg > TIME_W'(elapsed)) ? remaining_reg - TIME_W'(elapsed) : '0;
        wait_dec = (wait_reg > TIME_W'(elapsed)) ? wait_reg - TIME_W'(elapsed) : '0;
    end

    // Mode decision for one step
    always_comb begin
        mode_next      = mode_reg;
        remaining_next = remaining_reg;
        saved_next     = saved_reg;
        wait_next      = wait_reg;
        case (mode_reg)
            MODE_OFF: begin
                if (s_pressed) begin
                    remaining_next = duration_reg;
                    mode_next      = MODE_RUN;
                end
            end
            MODE_RUN: begin
                remaining_next = rem_dec;
                // completion wins over release
                if (rem_dec == '0) begin
                    wait_next = HOLD_LOAD;
                    mode_next = MODE_FIN;
                end else if (!s_pressed) begin
                    saved_next = rem_dec;
                    wait_next  = pause_timeout_reg;
                    mode_next  = MODE_INT;
                end
            end
            MODE_INT: begin
                wait_next = wait_dec;
                // press wins over timeout
                if (s_pressed) begin
                    remaining_next = saved_reg;
                    mode_next      = MODE_RUN;
                end else if (wait_dec == '0) begin
                    mode_next = MODE_OFF;
                end
            end
            MODE_FIN: begin
                wait_next = wait_dec;
                if (wait_dec == '0 && !s_pressed) begin
                    mode_next = MODE_OFF;
                end
            end
            default: ;
        endcase
    end

    // Sequencer next state
    always_comb begin
        accept     = s_valid && (state_reg == ST_IDLE);
        need_div   = (mode_next == MODE_RUN) && (duration_reg != '0);
        out_free   = !m_valid_reg || m_ready;
        push       = (state_reg == ST_PUSH) && out_free;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (accept) state_next = need_div ? ST_START : ST_PUSH;
            ST_START: state_next = ST_DIV;
            ST_DIV:   if (div_rsp.done) state_next = ST_PUSH;
            ST_PUSH:  if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Percentage: remaining * 100 / duration, capped at 100
    always_comb begin
        div_req.start    = (state_reg == ST_START);
        div_req.dividend = DIVIDEND_W'(remaining_reg) * DIVIDEND_W'(PCT_FULL);
        div_req.divisor  = duration_reg;
        pct_capped       = (div_rsp.quotient > DIVIDEND_W'(PCT_FULL)) ? PCT_FULL
                                                                      : div_rsp.quotient[PCT_W-1:0];
    end

    // Mode state and shown values
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg            <= MODE_OFF;
            remaining_reg       <= '0;
            saved_reg           <= '0;
            wait_reg            <= '0;
            shown_progress_reg  <= PCT_FULL;
            shown_time_left_reg <= '0;
        end else if (accept) begin
            mode_reg       <= mode_next;
            remaining_reg  <= remaining_next;
            saved_reg      <= saved_next;
            wait_reg       <= wait_next;
            case (mode_next)
                MODE_OFF: begin
                    shown_progress_reg  <= PCT_FULL;
                    shown_time_left_reg <= duration_reg;
                end
                MODE_RUN: begin
                    // zero duration shows 0; otherwise filled in by the divider
                    shown_progress_reg  <= '0;
                    shown_time_left_reg <= remaining_next;
                end
                MODE_FIN: begin
                    shown_progress_reg  <= '0;
                    shown_time_left_reg <= '0;
                end
                default: ;  // interrupted: hold
            endcase
        end else if (state_reg == ST_DIV && div_rsp.done) begin
            shown_progress_reg <= pct_capped;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (push) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            m_relay_on_reg  <= (mode_reg == MODE_RUN);
            m_mode_reg      <= mode_reg;
            m_progress_reg  <= shown_progress_reg;
            m_time_left_reg <= shown_time_left_reg;
        end
    end

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_relay_on     = m_relay_on_reg;
    assign m_mode         = m_mode_reg;
    assign m_progress_pct = m_progress_reg;
    assign m_time_left_ms = m_time_left_reg;

    // Relay drive agrees with the reported mode
    a_relay_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_relay_on == (m_mode == MODE_RUN)))
        else $error("relay level disagrees with mode");

    // Finished hold always reports an empty run
    a_fin_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PUSH && mode_reg == MODE_FIN)
            |-> (shown_progress_reg == '0 && shown_time_left_reg == '0))
        else $error("finished hold with nonzero progress or time");

    // Percentage never exceeds full scale in a result
    a_pct_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_progress_pct <= PCT_FULL))
        else $error("progress above 100 percent");

endmodule
